// ===== rtl/ttc_pkg.sv =====
// Shared types, constants and the log table of the tower timing calibration block.
package ttc_pkg;

   localparam int ROWS_DEF    = 48;
   localparam int COLUMNS_DEF = 96;
   localparam int SECTORS_DEF = 4;
   localparam int ARMS_DEF    = 2;

   localparam int TADDR_W   = 16;   // covers the largest tower store
   localparam int SIDX_W    = 3;    // covers the largest sector count
   localparam int QDEPTH    = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [16:0] GAIN_ONE  = 17'd65536;
   localparam logic [16:0] GAIN_PBSC = 17'd62654;
   localparam logic [16:0] GAIN_LATE = 17'd79399;
   localparam int LN2_Q16      = 45426;
   localparam int OFFS_091_Q16 = 59638;
   localparam int COEF_017_Q16 = 11141;
   localparam logic [19:0] E_ONE = 20'd1024;

   typedef enum logic [1:0] {
      OP_TOWER   = 2'd0,
      OP_SECTOR  = 2'd1,
      OP_CORRECT = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEAN_REF = 2'd0,
      CSR_LATE_RUN = 2'd1
   } csr_type;

   typedef struct packed {
      op_type                   op;
      logic                     sec_ok;
      logic                     twr_ok;
      logic [SIDX_W-1:0]        sidx;
      logic [TADDR_W-1:0]       taddr;
      logic [16:0]              gain;
      logic signed [23:0]       offset;
      logic signed [23:0]       tof_main;
      logic signed [23:0]       tof_low;
      logic signed [23:0]       tof_high;
      logic                     big_e;
      logic [18:0]              lnv;
   } item_type;

   typedef logic [15:0] ln_tab_type [256];

   function automatic ln_tab_type build_ln_table();
      ln_tab_type t;
      real        x;
      for (int f = 0; f < 256; f++) begin
         x = 65536.0 * $ln(1.0 + real'(f) / 256.0) + 0.5;
         t[f] = 16'($rtoi(x));
      end
      return t;
   endfunction

   localparam ln_tab_type LN_TABLE = build_ln_table();

endpackage

// ===== rtl/tower_timing_calibration.sv =====
// Top level of the tower timing calibration block.
//
// One item is taken per clock while busy is low; busy is high only during
// reset, so in practice every cycle can carry an item. Func 0 and 1 load a
// tower or sector offset and give no result; func 2 gives one result, which
// passes from the edge that took it through two front stages (range checks,
// store address, leading-one search, log table), one queue slot, and four
// back stages (offset store read, offset removal and log square, gain
// multiplies, rounding, energy shift and saturation). Results come on
// rsp_strobe for a single cycle and cannot be held off; the back end never
// stalls, so the queue stays nearly empty. Out-of-range addresses give
// index_error with zero times. Tower offsets come from one memory of
// ARMS*SECTORS*ROWS*COLUMNS entries, undefined until loaded. Write the
// configuration registers only while no item is in flight.
module tower_timing_calibration #(
   parameter int ROWS    = ttc_pkg::ROWS_DEF,
   parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
   parameter int SECTORS = ttc_pkg::SECTORS_DEF,
   parameter int ARMS    = ttc_pkg::ARMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_func,
   input  logic                req_arm,
   input  logic [1:0]          req_sector,
   input  logic [5:0]          req_row,
   input  logic [6:0]          req_column,
   input  logic signed [23:0]  req_offset_value,
   input  logic signed [23:0]  req_tof_main,
   input  logic signed [23:0]  req_tof_low,
   input  logic signed [23:0]  req_tof_high,
   input  logic [19:0]         req_energy,
   output logic                rsp_strobe,
   output logic signed [23:0]  rsp_tof_main_out,
   output logic signed [23:0]  rsp_tof_low_out,
   output logic signed [23:0]  rsp_tof_high_out,
   output logic                rsp_index_error,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ttc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]         csr_data
);
   import ttc_pkg::*;

   localparam int CW = $clog2(QDEPTH + 1);

   logic signed [23:0] mean_ref_ff;
   logic               late_run_ff;
   logic               take;
   logic [1:0]         front_fill;
   logic               push, pop, q_valid;
   logic [CW-1:0]      q_count;
   item_type           push_item, head_item;

   // configuration registers; always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ref_ff <= '0;
         late_run_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MEAN_REF: mean_ref_ff <= $signed(csr_data);
            CSR_LATE_RUN: late_run_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // hold off new items when everything in flight could fill the queue
   assign busy = reset || ((int'(q_count) + int'(front_fill)) >= QDEPTH);
   assign take = start && !busy;

   ttc_front #(.ROWS(ROWS), .COLUMNS(COLUMNS), .SECTORS(SECTORS), .ARMS(ARMS)) u_front (
      .clock(clock), .reset(reset), .take(take),
      .req_func(req_func), .req_arm(req_arm), .req_sector(req_sector),
      .req_row(req_row), .req_column(req_column),
      .req_offset_value(req_offset_value), .req_tof_main(req_tof_main),
      .req_tof_low(req_tof_low), .req_tof_high(req_tof_high),
      .req_energy(req_energy), .late_run(late_run_ff),
      .fill(front_fill), .push(push), .item(push_item)
   );

   ttc_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .not_empty(q_valid), .count(q_count), .head(head_item)
   );

   ttc_back #(.ROWS(ROWS), .COLUMNS(COLUMNS), .SECTORS(SECTORS), .ARMS(ARMS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(head_item),
      .mean_ref(mean_ref_ff), .q_pop(pop),
      .rsp_strobe(rsp_strobe), .rsp_tof_main_out(rsp_tof_main_out),
      .rsp_tof_low_out(rsp_tof_low_out), .rsp_tof_high_out(rsp_tof_high_out),
      .rsp_index_error(rsp_index_error)
   );

endmodule

// ===== rtl/ttc_front.sv =====
// Front end: accept, classify, address and energy log of each item.
module ttc_front #(
   parameter int ROWS    = ttc_pkg::ROWS_DEF,
   parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
   parameter int SECTORS = ttc_pkg::SECTORS_DEF,
   parameter int ARMS    = ttc_pkg::ARMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [1:0]          req_func,
   input  logic                req_arm,
   input  logic [1:0]          req_sector,
   input  logic [5:0]          req_row,
   input  logic [6:0]          req_column,
   input  logic signed [23:0]  req_offset_value,
   input  logic signed [23:0]  req_tof_main,
   input  logic signed [23:0]  req_tof_low,
   input  logic signed [23:0]  req_tof_high,
   input  logic [19:0]         req_energy,
   input  logic                late_run,
   output logic [1:0]          fill,
   output logic                push,
   output ttc_pkg::item_type   item
);
   import ttc_pkg::*;

   logic               a_vld_ff;
   logic [1:0]         a_func_ff;
   logic               a_arm_ff;
   logic [1:0]         a_sec_ff;
   logic [5:0]         a_row_ff;
   logic [6:0]         a_col_ff;
   logic signed [23:0] a_off_ff, a_tm_ff, a_tl_ff, a_th_ff;
   logic [19:0]        a_e_ff;

   logic               c_vld_ff;
   item_type           c_item_ff;
   logic [4:0]         c_k_ff;
   logic [19:0]        c_e_ff;

   item_type           c_item_in;
   logic [4:0]         k_in;
   logic [7:0]         frac;
   int                 sidx_int;
   int                 taddr_int;
   int                 lnv_int;

   // stage a: hold the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= take;
      end
      if (take) begin
         a_func_ff <= req_func;
         a_arm_ff  <= req_arm;
         a_sec_ff  <= req_sector;
         a_row_ff  <= req_row;
         a_col_ff  <= req_column;
         a_off_ff  <= req_offset_value;
         a_tm_ff   <= req_tof_main;
         a_tl_ff   <= req_tof_low;
         a_th_ff   <= req_tof_high;
         a_e_ff    <= req_energy;
      end
   end

   // classify: range checks, store addresses, gain, leading one of energy
   always_comb begin
      k_in = 5'd0;
      for (int i = 0; i < 20; i++) begin
         if (a_e_ff[i]) begin
            k_in = 5'(i);
         end
      end
      sidx_int  = int'(a_arm_ff) * SECTORS + int'(a_sec_ff);
      taddr_int = (sidx_int * ROWS + int'(a_row_ff)) * COLUMNS + int'(a_col_ff);
      c_item_in          = '0;
      c_item_in.op       = op_type'(a_func_ff);
      c_item_in.sec_ok   = (int'(a_arm_ff) < ARMS) && (int'(a_sec_ff) < SECTORS);
      c_item_in.twr_ok   = c_item_in.sec_ok && (int'(a_row_ff) < ROWS)
                           && (int'(a_col_ff) < COLUMNS);
      c_item_in.sidx     = SIDX_W'(sidx_int);
      c_item_in.taddr    = TADDR_W'(taddr_int);
      c_item_in.offset   = a_off_ff;
      c_item_in.tof_main = a_tm_ff;
      c_item_in.tof_low  = a_tl_ff;
      c_item_in.tof_high = a_th_ff;
      c_item_in.big_e    = a_e_ff > E_ONE;
      if (a_arm_ff && !a_sec_ff[1]) begin
         c_item_in.gain = GAIN_ONE;
      end else if (!a_arm_ff && a_sec_ff[1] && late_run) begin
         c_item_in.gain = GAIN_LATE;
      end else begin
         c_item_in.gain = GAIN_PBSC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= a_vld_ff;
      end
      c_item_ff <= c_item_in;
      c_k_ff    <= k_in;
      c_e_ff    <= a_e_ff;
   end

   // ln E + 0.91 in Q16; only used when energy exceeds one unit, so k >= 10
   always_comb begin
      frac    = (c_k_ff >= 5'd8) ? 8'(c_e_ff >> (c_k_ff - 5'd8)) : 8'd0;
      lnv_int = (int'(c_k_ff) - 10) * LN2_Q16 + int'(LN_TABLE[frac]) + OFFS_091_Q16;
      item     = c_item_ff;
      item.lnv = c_item_ff.big_e ? 19'(lnv_int) : 19'd0;
   end

   // drop unused codes and out-of-range loads here
   assign push = c_vld_ff && ((c_item_ff.op == OP_CORRECT)
                 || (c_item_ff.op == OP_TOWER && c_item_ff.twr_ok)
                 || (c_item_ff.op == OP_SECTOR && c_item_ff.sec_ok));

   assign fill = {1'b0, a_vld_ff} + {1'b0, c_vld_ff};

endmodule

// ===== rtl/ttc_queue.sv =====
// Short item queue between the front end and the back end.
module ttc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttc_pkg::item_type   push_item,
   input  logic                pop,
   output logic                not_empty,
   output logic [$clog2(ttc_pkg::QDEPTH+1)-1:0] count,
   output ttc_pkg::item_type   head
);
   import ttc_pkg::*;

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   item_type        slot_ff [QDEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;
   logic            do_pop;

   assign do_pop    = pop && (cnt_ff != '0);
   assign not_empty = cnt_ff != '0;
   assign count     = cnt_ff;
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(do_pop);
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/ttc_back.sv =====
// Back end: offset stores, gain scaling, energy shift and saturation.
module ttc_back #(
   parameter int ROWS    = ttc_pkg::ROWS_DEF,
   parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
   parameter int SECTORS = ttc_pkg::SECTORS_DEF,
   parameter int ARMS    = ttc_pkg::ARMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  ttc_pkg::item_type   q_item,
   input  logic signed [23:0]  mean_ref,
   output logic                q_pop,
   output logic                rsp_strobe,
   output logic signed [23:0]  rsp_tof_main_out,
   output logic signed [23:0]  rsp_tof_low_out,
   output logic signed [23:0]  rsp_tof_high_out,
   output logic                rsp_index_error
);
   import ttc_pkg::*;

   localparam int NSEC   = ARMS * SECTORS;
   localparam int SBITS  = (NSEC > 1) ? $clog2(NSEC) : 1;
   localparam int TDEPTH = NSEC * ROWS * COLUMNS;
   localparam int TBITS  = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

   logic signed [23:0] tower_mem [TDEPTH];
   logic signed [23:0] sec_off_ff [NSEC];
   logic signed [23:0] tow_rd_ff;

   // stage 1
   logic               s1_vld_ff;
   item_type           s1_item_ff;
   logic signed [23:0] s1_soff_ff;
   // stage 2
   logic               s2_vld_ff, s2_err_ff, s2_cor_ff;
   logic [16:0]        s2_gain_ff;
   logic signed [25:0] s2_d_ff [3];
   logic [37:0]        s2_a2_ff;
   logic               s2_big_ff;
   // stage 3
   logic               s3_vld_ff, s3_err_ff, s3_cor_ff;
   logic signed [43:0] s3_prod_ff [3];
   logic signed [41:0] s3_gm_ff;
   logic [51:0]        s3_sh_ff;

   logic signed [25:0] d_in [3];
   logic signed [23:0] t_in [3];
   logic signed [17:0] gain_s, gdiff_s;
   logic [51:0]        sh_round;
   logic [11:0]        shift_in;
   logic signed [45:0] acc_in [3];
   logic signed [30:0] q_in [3];
   logic signed [23:0] out_in [3];

   assign q_pop = q_valid;

   // pop: touch the stores; loads and reads stay in order
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         for (int i = 0; i < NSEC; i++) begin
            sec_off_ff[i] <= '0;
         end
      end else begin
         s1_vld_ff <= q_valid;
         if (q_valid && q_item.op == OP_SECTOR && q_item.sec_ok) begin
            sec_off_ff[q_item.sidx[SBITS-1:0]] <= q_item.offset;
         end
      end
      s1_item_ff <= q_item;
      s1_soff_ff <= sec_off_ff[q_item.sidx[SBITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_item.op == OP_TOWER && q_item.twr_ok) begin
         tower_mem[q_item.taddr[TBITS-1:0]] <= q_item.offset;
      end
      tow_rd_ff <= tower_mem[q_item.taddr[TBITS-1:0]];
   end

   // stage 1: remove offsets, square the log term
   always_comb begin
      t_in[0] = s1_item_ff.tof_main;
      t_in[1] = s1_item_ff.tof_low;
      t_in[2] = s1_item_ff.tof_high;
      for (int i = 0; i < 3; i++) begin
         d_in[i] = 26'(t_in[i]) - 26'(s1_soff_ff) - 26'(tow_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_err_ff  <= !s1_item_ff.twr_ok;
      s2_cor_ff  <= s1_item_ff.op == OP_CORRECT;
      s2_gain_ff <= s1_item_ff.gain;
      s2_big_ff  <= s1_item_ff.big_e;
      s2_a2_ff   <= 38'(s1_item_ff.lnv) * 38'(s1_item_ff.lnv);
      for (int i = 0; i < 3; i++) begin
         s2_d_ff[i] <= d_in[i];
      end
   end

   // stage 2: gain products
   assign gain_s  = $signed({1'b0, s2_gain_ff});
   assign gdiff_s = gain_s - $signed({1'b0, GAIN_ONE});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_err_ff <= s2_err_ff;
      s3_cor_ff <= s2_cor_ff;
      s3_gm_ff  <= 42'(gdiff_s) * 42'(mean_ref);
      s3_sh_ff  <= s2_big_ff ? (52'(s2_a2_ff) * 52'(COEF_017_Q16)) : 52'd0;
      for (int i = 0; i < 3; i++) begin
         s3_prod_ff[i] <= 44'(gain_s) * 44'(s2_d_ff[i]);
      end
   end

   // stage 3: round, subtract shift, saturate
   always_comb begin
      sh_round = s3_sh_ff + (52'd1 << 39);
      shift_in = sh_round[51:40];
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = 46'(s3_prod_ff[i]) - 46'(s3_gm_ff) + 46'sd32768;
         q_in[i]   = 31'(acc_in[i] >>> 16) - $signed({19'd0, shift_in});
         if (q_in[i] > 31'sd8388607) begin
            out_in[i] = 24'sd8388607;
         end else if (q_in[i] < -31'sd8388608) begin
            out_in[i] = -24'sd8388608;
         end else begin
            out_in[i] = 24'(q_in[i]);
         end
         if (s3_err_ff) begin
            out_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= s3_vld_ff && s3_cor_ff;
      end
      rsp_tof_main_out <= out_in[0];
      rsp_tof_low_out  <= out_in[1];
      rsp_tof_high_out <= out_in[2];
      rsp_index_error  <= s3_err_ff;
   end

endmodule

// ===== rtl/ttc_checker.sv =====
// Port-level checks of the tower timing calibration block, bound to the top level.
module ttc_checker #(
   parameter int ROWS    = ttc_pkg::ROWS_DEF,
   parameter int COLUMNS = ttc_pkg::COLUMNS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [1:0]          req_func,
   input logic [5:0]          req_row,
   input logic [6:0]          req_column,
   input logic                rsp_strobe,
   input logic signed [23:0]  rsp_tof_main_out,
   input logic signed [23:0]  rsp_tof_low_out,
   input logic signed [23:0]  rsp_tof_high_out,
   input logic                rsp_index_error
);
   import ttc_pkg::*;

   logic take_cor;
   assign take_cor = start && !busy && (req_func == OP_CORRECT);

   // a result follows each correct item, and only then
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(take_cor, 7))
      else $error("result strobe does not match correct items");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_index_error) |->
         (rsp_tof_main_out == 0 && rsp_tof_low_out == 0 && rsp_tof_high_out == 0))
      else $error("index error with nonzero times");

   a_err_flag: assert property (@(posedge clock) disable iff (reset)
      ($past(take_cor, 7) && ($past(int'(req_row), 7) >= ROWS
         || $past(int'(req_column), 7) >= COLUMNS)) |-> rsp_index_error)
      else $error("out-of-range tower not flagged");

endmodule

bind tower_timing_calibration ttc_checker #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_ttc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_func(req_func), .req_row(req_row), .req_column(req_column),
   .rsp_strobe(rsp_strobe), .rsp_tof_main_out(rsp_tof_main_out),
   .rsp_tof_low_out(rsp_tof_low_out), .rsp_tof_high_out(rsp_tof_high_out),
   .rsp_index_error(rsp_index_error)
);
